FILE: rtl/core/dmsa_pkg.sv
// ----------------------------------------------------------------------------
// dmsa_pkg
// Shared types and codes for the device minor slot allocator.
// ----------------------------------------------------------------------------
package dmsa_pkg;

  localparam int MINOR_W    = 8;
  localparam int NIB_W      = 4;
  localparam int LIMIT_W    = 5;
  localparam int HANDLE_W   = 16;
  localparam int STATUS_W   = 3;
  localparam int MODE_W     = 2;
  localparam int MINOR_COUNT = 256;

  // request kinds
  localparam logic [MODE_W-1:0] MODE_FIRST_FREE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_AT_INDEX   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_UNREGISTER = 2'd2;
  localparam logic [MODE_W-1:0] MODE_OPEN       = 2'd3;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NO_FREE   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BUSY      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_MISSING   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NO_DEVICE = 3'd5;

  // classes folded onto a shared class on open
  localparam logic [NIB_W-1:0] CLASS_ALIAS_A = 4'd4;
  localparam logic [NIB_W-1:0] CLASS_ALIAS_B = 4'd5;
  localparam logic [NIB_W-1:0] CLASS_SHARED  = 4'd3;

  typedef logic [MINOR_W-1:0]  minor_t;
  typedef logic [NIB_W-1:0]    nib_t;
  typedef logic [HANDLE_W-1:0] handle_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [MODE_W-1:0]   mode_t;

endpackage

FILE: rtl/core/dmsa_if.sv
// ----------------------------------------------------------------------------
// dmsa_if
// Valid/ready channels for requests and results of the slot allocator.
// ----------------------------------------------------------------------------
interface dmsa_in_if;
  import dmsa_pkg::*;
  logic                 valid;
  logic                 ready;
  mode_t                mode;
  nib_t                 device_class;
  nib_t                 first_slot;
  logic [LIMIT_W-1:0]   slot_limit;
  nib_t                 slot_index;
  minor_t               minor_number;
  handle_t              entry_handle;

  modport source (output valid, mode, device_class, first_slot, slot_limit, slot_index,
                  minor_number, entry_handle, input ready);
  modport sink   (input valid, mode, device_class, first_slot, slot_limit, slot_index,
                  minor_number, entry_handle, output ready);
endinterface

interface dmsa_out_if;
  import dmsa_pkg::*;
  logic    valid;
  logic    ready;
  status_t status;
  minor_t  result_minor;
  handle_t result_handle;

  modport source (output valid, status, result_minor, result_handle, input ready);
  modport sink   (input valid, status, result_minor, result_handle, output ready);
endinterface

FILE: rtl/core/dmsa_ram.sv
// ----------------------------------------------------------------------------
// dmsa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dmsa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/device_minor_slot_allocator.sv
// every request passes through LOOK and FIN before its result enters the output register;
//   in mode 0 with an in-range class, SCAN lies between them, one 4-slot group
//   of the free-slot scanner per cycle
// throughput: one request at a time, a new one is taken once the result has
//   entered the output register
// reset clears the whole occupancy map; the handle RAM is not cleared
// ----------------------------------------------------------------------------
// device_minor_slot_allocator
// Per-class occupancy map and handle store for 8-bit minor numbers, with a
// sequenced lowest-free-slot scanner.
// ----------------------------------------------------------------------------
module device_minor_slot_allocator #(
  parameter int SLOTS_PER_CLASS = 16,
  parameter int CLASS_COUNT     = 16,
  parameter int HANDLE_BITS     = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  dmsa_in_if.sink     in_ch,
  dmsa_out_if.source  out_ch
);
  import dmsa_pkg::*;

  localparam int SIW  = $clog2(SLOTS_PER_CLASS);
  localparam int CIW  = $clog2(CLASS_COUNT);
  localparam int GRP  = 4;
  localparam int NGRP = (SLOTS_PER_CLASS + GRP - 1) / GRP;
  localparam int GW   = (NGRP > 1) ? $clog2(NGRP) : 1;
  localparam int CW   = NGRP * GRP;
  localparam int AW   = $clog2(MINOR_COUNT);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOOK = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]                 state_r, state_nxt;
  mode_t                      mode_r;
  nib_t                       device_class_r, first_slot_r, slot_index_r;
  logic [LIMIT_W-1:0]         slot_limit_r;
  minor_t                     minor_number_r;
  handle_t                    entry_handle_r;

  logic [SLOTS_PER_CLASS-1:0] occ_r [CLASS_COUNT];
  logic [CW-1:0]              cand_r, cand_nxt;
  logic [GW-1:0]              grp_r, grp_nxt;
  nib_t                       slot_r, slot_nxt;
  status_t                    stat_r, stat_nxt;

  logic                       out_valid_r;
  status_t                    out_status_r;
  minor_t                     out_minor_r;
  handle_t                    out_handle_r;

  logic                       is_reg;
  nib_t                       tgt_cls;
  logic [LIMIT_W-1:0]         tgt_slot;
  logic [LIMIT_W-1:0]         lim;
  logic                       cls_ok, slot_ok, occ_bit;
  logic [SLOTS_PER_CLASS-1:0] row;
  logic [CW-1:0]              cand_calc;
  logic [GRP-1:0]             grp_bits;
  logic                       can_load, fin_load;
  logic                       ram_we, ram_re;
  logic [HANDLE_BITS-1:0]     ram_wdata, ram_rdata;
  handle_t                    rd_handle;

  function automatic logic [1:0] low_one(input logic [GRP-1:0] v);
    logic [1:0] p;
    if (v[0]) begin
      p = 2'd0;
    end else if (v[1]) begin
      p = 2'd1;
    end else if (v[2]) begin
      p = 2'd2;
    end else begin
      p = 2'd3;
    end
    return p;
  endfunction

  assign in_ch.ready = (state_r == S_IDLE);
  assign is_reg      = (mode_r == MODE_FIRST_FREE) || (mode_r == MODE_AT_INDEX);

  // target class and slot of the request, open folds alias classes
  always_comb begin
    if (is_reg) begin
      tgt_cls = device_class_r;
    end else if ((mode_r == MODE_OPEN) &&
                 ((minor_number_r[NIB_W-1:0] == CLASS_ALIAS_A) ||
                  (minor_number_r[NIB_W-1:0] == CLASS_ALIAS_B))) begin
      tgt_cls = CLASS_SHARED;
    end else begin
      tgt_cls = minor_number_r[NIB_W-1:0];
    end
    if (mode_r == MODE_AT_INDEX) begin
      tgt_slot = {1'b0, first_slot_r} + {1'b0, slot_index_r};
    end else if (is_reg) begin
      tgt_slot = {1'b0, first_slot_r};
    end else begin
      tgt_slot = {1'b0, minor_number_r[MINOR_W-1:NIB_W]};
    end
    cls_ok  = {1'b0, tgt_cls} < LIMIT_W'(CLASS_COUNT);
    slot_ok = tgt_slot < LIMIT_W'(SLOTS_PER_CLASS);
    row     = cls_ok ? occ_r[tgt_cls[CIW-1:0]] : '0;
    occ_bit = slot_ok ? row[tgt_slot[SIW-1:0]] : 1'b0;
    lim     = (slot_limit_r > LIMIT_W'(SLOTS_PER_CLASS)) ? LIMIT_W'(SLOTS_PER_CLASS)
                                                          : slot_limit_r;
  end

  // free slots inside [first, limit)
  always_comb begin
    cand_calc = '0;
    for (int s = 0; s < SLOTS_PER_CLASS; s++) begin
      cand_calc[s] = !row[s] && (LIMIT_W'(s) >= {1'b0, first_slot_r}) &&
                     (LIMIT_W'(s) < lim);
    end
  end

  assign grp_bits = cand_r[grp_r*GRP +: GRP];
  assign can_load = !out_valid_r || out_ch.ready;
  assign fin_load = (state_r == S_FIN) && can_load;

  always_comb begin
    state_nxt = state_r;
    cand_nxt  = cand_r;
    grp_nxt   = grp_r;
    slot_nxt  = slot_r;
    stat_nxt  = stat_r;
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        slot_nxt  = tgt_slot[NIB_W-1:0];
        state_nxt = S_FIN;
        case (mode_r)
          MODE_FIRST_FREE: begin
            cand_nxt = cand_calc;
            grp_nxt  = '0;
            if (cls_ok) begin
              state_nxt = S_SCAN;
            end else begin
              stat_nxt = ST_RANGE;
            end
          end
          MODE_AT_INDEX: begin
            if (!cls_ok || !slot_ok) begin
              stat_nxt = ST_RANGE;
            end else if (occ_bit) begin
              stat_nxt = ST_BUSY;
            end else begin
              stat_nxt = ST_OK;
            end
          end
          MODE_UNREGISTER: stat_nxt = occ_bit ? ST_OK : ST_MISSING;
          default:         stat_nxt = occ_bit ? ST_OK : ST_NO_DEVICE;
        endcase
      end
      S_SCAN: begin
        if (|grp_bits) begin
          slot_nxt  = NIB_W'({grp_r, low_one(grp_bits)});
          stat_nxt  = ST_OK;
          state_nxt = S_FIN;
        end else if (grp_r == GW'(NGRP - 1)) begin
          stat_nxt  = ST_NO_FREE;
          state_nxt = S_FIN;
        end else begin
          grp_nxt = grp_r + 1'b1;
        end
      end
      S_FIN: begin
        if (can_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // handle width conversion on the way in and out of the store
  always_comb begin
    for (int i = 0; i < HANDLE_BITS; i++) begin
      ram_wdata[i] = (i < HANDLE_W) ? entry_handle_r[i] : 1'b0;
    end
    for (int i = 0; i < HANDLE_W; i++) begin
      rd_handle[i] = (i < HANDLE_BITS) ? ram_rdata[i] : 1'b0;
    end
  end

  assign ram_we = fin_load && is_reg && (stat_r == ST_OK);
  assign ram_re = (state_r == S_LOOK) && (mode_r == MODE_OPEN);

  dmsa_ram #(
    .WIDTH (HANDLE_BITS),
    .DEPTH (MINOR_COUNT)
  ) u_handle_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'({slot_r, tgt_cls})),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (AW'({tgt_slot[NIB_W-1:0], tgt_cls})),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int c = 0; c < CLASS_COUNT; c++) begin
        occ_r[c] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (fin_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (fin_load && (stat_r == ST_OK)) begin
        if (is_reg) begin
          occ_r[tgt_cls[CIW-1:0]][slot_r[SIW-1:0]] <= 1'b1;
        end else if (mode_r == MODE_UNREGISTER) begin
          occ_r[tgt_cls[CIW-1:0]][slot_r[SIW-1:0]] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      mode_r         <= in_ch.mode;
      device_class_r <= in_ch.device_class;
      first_slot_r   <= in_ch.first_slot;
      slot_limit_r   <= in_ch.slot_limit;
      slot_index_r   <= in_ch.slot_index;
      minor_number_r <= in_ch.minor_number;
      entry_handle_r <= in_ch.entry_handle;
    end
    cand_r <= cand_nxt;
    grp_r  <= grp_nxt;
    slot_r <= slot_nxt;
    stat_r <= stat_nxt;
    if (fin_load) begin
      out_status_r <= stat_r;
      out_minor_r  <= ((stat_r == ST_RANGE) || (stat_r == ST_NO_FREE)) ? '0
                                                                       : {slot_r, tgt_cls};
      out_handle_r <= ((mode_r == MODE_OPEN) && (stat_r == ST_OK)) ? rd_handle : '0;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.result_minor  = out_minor_r;
  assign out_ch.result_handle = out_handle_r;

endmodule

FILE: rtl/core/dmsa_checker.sv
// ----------------------------------------------------------------------------
// dmsa_checker
// Port-level checks on the slot allocator, bound to the top level.
// ----------------------------------------------------------------------------
module dmsa_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input dmsa_pkg::status_t         status,
  input dmsa_pkg::minor_t          result_minor,
  input dmsa_pkg::handle_t         result_handle
);
  import dmsa_pkg::*;

  // one request in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while another is in flight");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status) &&
      $stable(result_minor) && $stable(result_handle))
    else $error("stalled result changed");

  // a handle is only reported with a good status
  a_handle_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (result_handle != '0) |-> status == ST_OK)
    else $error("handle reported on a failed request");

  // range and no-free errors carry a zero minor
  a_err_minor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((status == ST_RANGE) || (status == ST_NO_FREE)) |-> result_minor == '0)
    else $error("nonzero minor on a range or no-free result");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind device_minor_slot_allocator dmsa_checker u_dmsa_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .status        (out_ch.status),
  .result_minor  (out_ch.result_minor),
  .result_handle (out_ch.result_handle)
);
